>>> hdl/clw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_pkg
// Shared types, command codes and defaults for the circular log.
// ----------------------------------------------------------------------------
package clw_pkg;

	localparam int LOG_ENTRIES_DEF = 1024;
	localparam int ENTRY_BITS_DEF  = 64;

	localparam int DATA_W     = 64;
	localparam int IDX_W      = 10;
	localparam int CNT_PORT_W = 11;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_READ   = 2'd1;
	localparam logic [1:0] CMD_MARK   = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	typedef struct packed {
		logic [1:0]            cmd;
		logic [DATA_W-1:0]     entry_data;
		logic [IDX_W-1:0]      read_index;
		logic [CNT_PORT_W-1:0] mark_count;
	} in_item_t;

	typedef struct packed {
		logic                  ok;
		logic [DATA_W-1:0]     entry_out;
		logic [CNT_PORT_W-1:0] pending_now;
		logic [CNT_PORT_W-1:0] stored_now;
	} out_item_t;

	// command status handed from the pointer logic to the result stage
	typedef struct packed {
		logic                  ok;
		logic                  rd_hit;
		logic [CNT_PORT_W-1:0] pending;
		logic [CNT_PORT_W-1:0] stored;
	} rsp_stat_t;

endpackage

>>> hdl/clw_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_chan_if
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
interface clw_chan_if #(parameter type item_t = logic) ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/clw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module clw_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

>>> hdl/clw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clw_ctrl
// Head/tail pointers and counts; decodes each item into a store access.
// ----------------------------------------------------------------------------
module clw_ctrl #(
	parameter int LOG_ENTRIES = clw_pkg::LOG_ENTRIES_DEF,
	localparam int PTR_W      = $clog2(LOG_ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                acc,
	input  clw_pkg::in_item_t   item,
	output logic                mem_we,
	output logic [PTR_W-1:0]    mem_waddr,
	output logic                mem_re,
	output logic [PTR_W-1:0]    mem_raddr,
	output clw_pkg::rsp_stat_t  stat
);
	import clw_pkg::*;

	localparam int CNT_W = $clog2(LOG_ENTRIES + 1);
	localparam int WW    = ((CNT_W > CNT_PORT_W) ? CNT_W : CNT_PORT_W) + 2;

	logic [PTR_W-1:0] head_q, tail_q, head_d, tail_d;
	logic [PTR_W-1:0] head_nxt, tail_nxt;
	logic [CNT_W-1:0] valid_q, unsent_q, valid_d, unsent_d;
	logic [WW-1:0]    idx_w, cnt_w, uns_w, pos;
	logic             rd_ok, rd_hit;
	logic [WW-1:0]    chk_sum;
	logic [PTR_W-1:0] chk_head;

	assign head_nxt  = (head_q == PTR_W'(LOG_ENTRIES - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt  = (tail_q == PTR_W'(LOG_ENTRIES - 1)) ? '0 : tail_q + 1'b1;
	assign mem_waddr = head_q;

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		valid_d  = valid_q;
		unsent_d = unsent_q;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		rd_ok    = 1'b1;
		rd_hit   = 1'b0;
		idx_w    = WW'(item.read_index);
		cnt_w    = WW'(item.mark_count);
		uns_w    = WW'(unsent_q);
		// oldest pending slot plus offset, modulo ring size
		pos = WW'(head_q) + WW'(LOG_ENTRIES) - uns_w + idx_w;
		if (pos >= WW'(LOG_ENTRIES)) begin
			pos = pos - WW'(LOG_ENTRIES);
		end
		mem_raddr = pos[PTR_W-1:0];
		unique case (item.cmd)
			CMD_APPEND: begin
				mem_we = acc;
				head_d = head_nxt;
				if (valid_q == CNT_W'(LOG_ENTRIES)) begin
					tail_d = tail_nxt;
				end else begin
					valid_d = valid_q + 1'b1;
				end
				if (unsent_q != CNT_W'(LOG_ENTRIES)) begin
					unsent_d = unsent_q + 1'b1;
				end
			end
			CMD_READ: begin
				rd_ok  = idx_w < uns_w;
				rd_hit = rd_ok;
				mem_re = acc && rd_ok;
			end
			CMD_MARK: begin
				unsent_d = (cnt_w >= uns_w) ? '0 : CNT_W'(uns_w - cnt_w);
			end
			CMD_CLEAR: begin
				head_d   = '0;
				tail_d   = '0;
				valid_d  = '0;
				unsent_d = '0;
			end
			default: begin
			end
		endcase
	end

	assign stat.ok      = rd_ok;
	assign stat.rd_hit  = rd_hit;
	assign stat.pending = CNT_PORT_W'(unsent_d);
	assign stat.stored  = CNT_PORT_W'(valid_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			valid_q  <= '0;
			unsent_q <= '0;
		end else if (acc) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			valid_q  <= valid_d;
			unsent_q <= unsent_d;
		end
	end

	// head must sit valid_count slots past the tail
	always_comb begin
		chk_sum  = WW'(tail_q) + WW'(valid_q);
		chk_head = (chk_sum >= WW'(LOG_ENTRIES)) ?
			PTR_W'(chk_sum - WW'(LOG_ENTRIES)) : PTR_W'(chk_sum);
	end

	a_pending_le_valid: assert property (@(posedge clk) disable iff (!arst_n)
		unsent_q <= valid_q)
		else $error("pending count above stored count");

	a_valid_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q <= CNT_W'(LOG_ENTRIES))
		else $error("stored count above ring size");

	a_ring_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		head_q == chk_head)
		else $error("head, tail and stored count disagree");

	a_append_stores: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.cmd == CMD_APPEND |=> valid_q != '0 && unsent_q != '0)
		else $error("append left log or pending window empty");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		acc && item.cmd == CMD_CLEAR |=> head_q == '0 && valid_q == '0 && unsent_q == '0)
		else $error("clear left state behind");
endmodule

>>> hdl/circular_log_with_pending_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_log_with_pending_window
// Overwriting ring log with a window of pending (untransmitted) entries.
// ----------------------------------------------------------------------------
// Takes one command item per cycle unless the output stalls, and returns
// one result item in the cycle after acceptance. Pointers and counts update
// at the accepting edge; the entry store is a single synchronous RAM with
// one write and one read port whose registered read data is the result
// output, so a read may directly follow an append of the same slot. A result
// waiting on a stalled output holds its slot, and the next command is taken
// as soon as it leaves. No clearing pass is needed after reset.
module circular_log_with_pending_window #(
	parameter int LOG_ENTRIES = clw_pkg::LOG_ENTRIES_DEF,
	parameter int ENTRY_BITS  = clw_pkg::ENTRY_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	clw_chan_if.sink   req,
	clw_chan_if.source rsp
);
	import clw_pkg::*;

	localparam int PTR_W = $clog2(LOG_ENTRIES);

	logic                  acc;
	logic                  mem_we, mem_re;
	logic [PTR_W-1:0]      mem_waddr, mem_raddr;
	logic [ENTRY_BITS-1:0] rdata;
	rsp_stat_t             stat, stat_s1;
	logic                  v_s1;

	assign req.ready = !v_s1 || rsp.ready;
	assign acc       = req.valid && req.ready;

	clw_ctrl #(
		.LOG_ENTRIES(LOG_ENTRIES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.acc      (acc),
		.item     (req.data),
		.mem_we   (mem_we),
		.mem_waddr(mem_waddr),
		.mem_re   (mem_re),
		.mem_raddr(mem_raddr),
		.stat     (stat)
	);

	clw_ram #(
		.DEPTH(LOG_ENTRIES),
		.WIDTH(ENTRY_BITS)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(req.data.entry_data[ENTRY_BITS-1:0]),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req.ready) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			stat_s1 <= stat;
		end
	end

	assign rsp.valid            = v_s1;
	assign rsp.data.ok          = stat_s1.ok;
	assign rsp.data.entry_out   = stat_s1.rd_hit ? DATA_W'(rdata) : '0;
	assign rsp.data.pending_now = stat_s1.pending;
	assign rsp.data.stored_now  = stat_s1.stored;
endmodule

>>> test/circular_log_with_pending_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_log_with_pending_window_tb
// Self-checking bench for the overwriting ring log with a pending window.
// ----------------------------------------------------------------------------
// A short directed table covers the empty log, out-of-window reads, marks
// beyond the pending count and clear. Random traffic follows: mixed
// commands, then one long run of appends that fills and wraps the log and
// reads across the whole 1024-entry window. Each accepted command is run
// through a local ring-log model and the result queue is checked in order.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module circular_log_with_pending_window_tb;
	import clw_pkg::*;

	localparam int RING_SIZE  = 1024;
	localparam int IDLE_LIMIT = 2000;

	logic clk;
	logic arst_n;

	clw_chan_if #(.item_t(in_item_t))  req_if ();
	clw_chan_if #(.item_t(out_item_t)) rsp_if ();

	circular_log_with_pending_window dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// local ring-log model
	logic [DATA_W-1:0] ring_mem [RING_SIZE];
	int unsigned       head_pos;
	int unsigned       stored_cnt;
	int unsigned       pend_cnt;

	out_item_t   due_results [$];
	int unsigned mismatches;
	int unsigned burst_left;
	bit          use_gaps;

	typedef struct {
		in_item_t  it;
		bit        typed;
		out_item_t res;
	} dir_row_t;

	dir_row_t plan [$];

	function automatic out_item_t ring_log_apply(input in_item_t it);
		out_item_t   r;
		int unsigned pos;
		r = '0;
		r.ok = 1'b1;
		case (it.cmd)
			CMD_APPEND: begin
				ring_mem[head_pos] = it.entry_data;
				head_pos = (head_pos + 1) % RING_SIZE;
				if (stored_cnt < RING_SIZE)
					stored_cnt++;
				pend_cnt++;
				if (pend_cnt > stored_cnt)
					pend_cnt = stored_cnt;
			end
			CMD_READ: begin
				if (it.read_index >= pend_cnt) begin
					r.ok = 1'b0;
				end else begin
					pos = (head_pos + RING_SIZE - pend_cnt + it.read_index) % RING_SIZE;
					r.entry_out = ring_mem[pos];
				end
			end
			CMD_MARK: begin
				if (it.mark_count >= pend_cnt)
					pend_cnt = 0;
				else
					pend_cnt -= it.mark_count;
			end
			default: begin
				head_pos   = 0;
				stored_cnt = 0;
				pend_cnt   = 0;
			end
		endcase
		r.pending_now = pend_cnt[CNT_PORT_W-1:0];
		r.stored_now  = stored_cnt[CNT_PORT_W-1:0];
		return r;
	endfunction

	function automatic void row(input logic [1:0] cmd, input logic [DATA_W-1:0] data,
			input int unsigned idx, input int unsigned cnt, input bit typed,
			input bit ok, input logic [DATA_W-1:0] eout,
			input int unsigned pend, input int unsigned stor);
		dir_row_t d;
		d.it.cmd        = cmd;
		d.it.entry_data = data;
		d.it.read_index = idx[IDX_W-1:0];
		d.it.mark_count = cnt[CNT_PORT_W-1:0];
		d.typed         = typed;
		d.res.ok          = ok;
		d.res.entry_out   = eout;
		d.res.pending_now = pend[CNT_PORT_W-1:0];
		d.res.stored_now  = stor[CNT_PORT_W-1:0];
		plan.push_back(d);
	endfunction

	function automatic in_item_t pick_cmd(input int unsigned w_app, input int unsigned w_rd,
			input int unsigned w_mark);
		in_item_t    it;
		int unsigned roll;
		it.cmd        = CMD_CLEAR;
		it.entry_data = {$urandom, $urandom};
		it.read_index = IDX_W'($urandom_range(0, RING_SIZE - 1));
		it.mark_count = CNT_PORT_W'($urandom_range(0, RING_SIZE));
		roll = $urandom_range(0, 99);
		if (roll < w_app) begin
			it.cmd = CMD_APPEND;
		end else if (roll < w_app + w_rd) begin
			it.cmd = CMD_READ;
			if (pend_cnt > 0 && $urandom_range(0, 9) < 7)
				it.read_index = IDX_W'($urandom_range(0, pend_cnt - 1));
		end else if (roll < w_app + w_rd + w_mark) begin
			it.cmd = CMD_MARK;
			case ($urandom_range(0, 4))
				0, 1: it.mark_count = CNT_PORT_W'($urandom_range(0, pend_cnt));
				2: it.mark_count = CNT_PORT_W'($urandom_range(0, 3));
				3: it.mark_count = CNT_PORT_W'(RING_SIZE);
				default: ;
			endcase
		end
		return it;
	endfunction

	task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	task automatic issue_cmd(input in_item_t it, input bit typed, input out_item_t typed_res);
		out_item_t res;
		int unsigned gap;
		if (use_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (burst_left > 0)
			burst_left--;
		req_if.valid <= 1'b1;
		req_if.data  <= it;
		do @(posedge clk); while (!req_if.ready);
		res = ring_log_apply(it);
		due_results.push_back(typed ? typed_res : res);
	endtask

	task automatic drain;
		req_if.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic run_mixed(input int unsigned n, input int unsigned w_app,
			input int unsigned w_rd, input int unsigned w_mark);
		repeat (n)
			issue_cmd(pick_cmd(w_app, w_rd, w_mark), 1'b0, '0);
	endtask

	// receiver stall pattern
	logic [15:0] stall_pat;
	int unsigned pat_left;
	int unsigned pat_pos;

	always @(posedge clk) begin
		if (pat_left == 0) begin
			stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
			pat_left  = $urandom_range(16, 128);
		end
		pat_left--;
		pat_pos = (pat_pos + 1) % 16;
		rsp_if.ready <= stall_pat[pat_pos];
	end

	always @(posedge clk) begin
		out_item_t want;
		out_item_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (due_results.size() == 0) begin
				flag_mismatch("unexpected item", got.entry_out, '0);
			end else begin
				want = due_results.pop_front();
				if (got.ok !== want.ok)
					flag_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
				if (got.entry_out !== want.entry_out)
					flag_mismatch("entry_out", got.entry_out, want.entry_out);
				if (got.pending_now !== want.pending_now)
					flag_mismatch("pending_now", DATA_W'(got.pending_now),
						DATA_W'(want.pending_now));
				if (got.stored_now !== want.stored_now)
					flag_mismatch("stored_now", DATA_W'(got.stored_now),
						DATA_W'(want.stored_now));
			end
		end
	end

	int unsigned idle_cycles;

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		in_item_t    it;
		int unsigned appends;
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		stall_pat    = 16'hFFFF;
		pat_left     = 0;
		pat_pos      = 0;
		idle_cycles  = 0;
		mismatches   = 0;
		burst_left   = 0;
		use_gaps     = 1'b1;
		head_pos     = 0;
		stored_cnt   = 0;
		pend_cnt     = 0;

		row(CMD_READ,   '0, 0, 0, 1, 0, '0, 0, 0);
		row(CMD_MARK,   '0, 0, RING_SIZE, 1, 1, '0, 0, 0);
		row(CMD_APPEND, '1, 0, 0, 1, 1, '0, 1, 1);
		row(CMD_APPEND, '0, 0, 0, 1, 1, '0, 2, 2);
		row(CMD_READ,   '0, 0, 0, 1, 1, '1, 2, 2);
		row(CMD_READ,   '1, 1, 0, 1, 1, '0, 2, 2);
		row(CMD_READ,   '0, 2, 0, 1, 0, '0, 2, 2);
		row(CMD_READ,   '0, RING_SIZE - 1, 0, 1, 0, '0, 2, 2);
		row(CMD_MARK,   '0, 0, 1, 1, 1, '0, 1, 2);
		row(CMD_READ,   '0, 0, 0, 1, 1, '0, 1, 2);
		row(CMD_APPEND, 64'hA5A5_5A5A_F00F_0FF0, 0, 0, 1, 1, '0, 2, 3);
		row(CMD_MARK,   '0, 0, 0, 1, 1, '0, 2, 3);
		row(CMD_READ,   '0, 1, 0, 0, 0, '0, 0, 0);
		row(CMD_MARK,   '1, '1, RING_SIZE, 1, 1, '0, 0, 3);
		row(CMD_READ,   '0, 0, 0, 1, 0, '0, 0, 3);
		row(CMD_APPEND, 64'h8000_0000_0000_0001, 0, 0, 1, 1, '0, 1, 4);
		row(CMD_READ,   '0, 0, 0, 1, 1, 64'h8000_0000_0000_0001, 1, 4);
		row(CMD_CLEAR,  '1, '1, '1, 1, 1, '0, 0, 0);
		row(CMD_READ,   '0, 0, 0, 1, 0, '0, 0, 0);
		row(CMD_APPEND, 64'h0123_4567_89AB_CDEF, 0, 0, 0, 0, '0, 0, 0);
		row(CMD_APPEND, 64'hFEDC_BA98_7654_3210, 0, 0, 0, 0, '0, 0, 0);
		row(CMD_READ,   '0, 1, 0, 0, 0, '0, 0, 0);
		row(CMD_MARK,   '0, 0, 1, 0, 0, '0, 0, 0);
		row(CMD_READ,   '0, 0, 0, 0, 0, '0, 0, 0);
		row(CMD_CLEAR,  '0, 0, 0, 1, 1, '0, 0, 0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue_cmd(plan[i].it, plan[i].typed, plan[i].res);
		drain();

		run_mixed(50, 45, 35, 16);
		drain();

		use_gaps = 1'b0;
		run_mixed(30, 50, 30, 17);
		use_gaps = 1'b1;

		// fill and wrap the log, reading across the whole window
		issue_cmd(pick_cmd(0, 0, 0), 1'b0, '0);
		appends = 0;
		while (appends < RING_SIZE + 16) begin
			it = pick_cmd(97, 3, 0);
			if (it.cmd == CMD_APPEND)
				appends++;
			issue_cmd(it, 1'b0, '0);
		end
		it = pick_cmd(0, 100, 0);
		it.read_index = IDX_W'(RING_SIZE - 1);
		issue_cmd(it, 1'b0, '0);
		it.read_index = '0;
		issue_cmd(it, 1'b0, '0);
		drain();

		run_mixed(30, 45, 30, 23);

		drain();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
